// File: src/pptf_pkg.sv
package pptf_pkg;

  // field widths
  localparam int unsigned COORD_W = 32;
  localparam int unsigned ANGLE_W = 16;
  localparam int unsigned SUM_W   = COORD_W + 1;

  // configuration port
  localparam int unsigned CFG_IDX_W  = 3;
  localparam int unsigned CFG_DATA_W = 32;

  localparam logic [CFG_IDX_W-1:0] REG_MOUNT_X   = 3'd0;
  localparam logic [CFG_IDX_W-1:0] REG_MOUNT_Y   = 3'd1;
  localparam logic [CFG_IDX_W-1:0] REG_MOUNT_ANG = 3'd2;
  localparam logic [CFG_IDX_W-1:0] REG_REF_X     = 3'd3;
  localparam logic [CFG_IDX_W-1:0] REG_REF_Y     = 3'd4;
  localparam logic [CFG_IDX_W-1:0] REG_REF_ANG   = 3'd5;

  // register reset values
  localparam logic signed [COORD_W-1:0] MOUNT_X_RST   = 32'sd13107;  // 0.2 m
  localparam logic signed [COORD_W-1:0] MOUNT_Y_RST   = '0;
  localparam logic signed [ANGLE_W-1:0] MOUNT_ANG_RST = '0;
  localparam logic signed [COORD_W-1:0] REF_X_RST     = '0;
  localparam logic signed [COORD_W-1:0] REF_Y_RST     = '0;
  localparam logic signed [ANGLE_W-1:0] REF_ANG_RST   = 16'sd8192;   // pi/4

  // result clip limits
  localparam logic signed [COORD_W-1:0] RES_MAX = 32'sh7fff_ffff;
  localparam logic signed [COORD_W-1:0] RES_MIN = 32'sh8000_0000;

  // default parameters
  localparam int unsigned CORDIC_STAGES_DEF = 16;
  localparam int unsigned FRAC_BITS_DEF     = 16;

  // arctangent table, 2^32 is a full turn
  localparam int unsigned ATAN_LEN = 24;
  localparam int unsigned ZW       = 32;
  localparam logic signed [ZW-1:0] ATAN_TAB [ATAN_LEN] = '{
    32'sd536870912, 32'sd316933406, 32'sd167458907, 32'sd85004756,
    32'sd42667331,  32'sd21354465,  32'sd10679838,  32'sd5340245,
    32'sd2670163,   32'sd1335087,   32'sd667544,    32'sd333772,
    32'sd166886,    32'sd83443,     32'sd41722,     32'sd20861,
    32'sd10430,     32'sd5215,      32'sd2608,      32'sd1304,
    32'sd652,       32'sd326,       32'sd163,       32'sd81
  };

  // point data that waits alongside the cordic pipes
  typedef struct packed {
    logic signed [SUM_W-1:0] x;
    logic signed [SUM_W-1:0] y;
    logic signed [SUM_W-1:0] dx;
    logic signed [SUM_W-1:0] dy;
  } pt_data_t;

endpackage

// File: src/pptf_cordic.sv
module pptf_cordic #(
  parameter int unsigned CORDIC_STAGES = pptf_pkg::CORDIC_STAGES_DEF,
  parameter int unsigned FRAC_BITS     = pptf_pkg::FRAC_BITS_DEF
) (
  input  logic                                  clk_i,
  input  logic                                  en_i,
  input  logic [pptf_pkg::ANGLE_W-1:0]          angle_i,
  output logic signed [FRAC_BITS+1:0]           cos_o,
  output logic signed [FRAC_BITS+1:0]           sin_o
);
  import pptf_pkg::*;

  localparam int unsigned NStg = (CORDIC_STAGES < ATAN_LEN) ? CORDIC_STAGES : ATAN_LEN;
  localparam int unsigned CW   = FRAC_BITS + 2;
  localparam longint      KRaw = (longint'(652032874) + (longint'(1) << (29 - FRAC_BITS)))
                                 >> (30 - FRAC_BITS);
  localparam logic signed [CW-1:0] KInit = CW'(KRaw);

  logic signed [CW-1:0] x_q [NStg+1];
  logic signed [CW-1:0] y_q [NStg+1];
  logic signed [ZW-1:0] z_q [NStg];
  logic                 flip_q [NStg+1];
  logic signed [CW-1:0] cos_q, sin_q;

  logic                 flip_d;
  logic [ANGLE_W-1:0]   ang_fold;

  // second and third quadrant: rotate by pi less, negate at the end
  always_comb begin
    flip_d   = angle_i[ANGLE_W-1] ^ angle_i[ANGLE_W-2];
    ang_fold = flip_d ? (angle_i ^ {1'b1, {(ANGLE_W-1){1'b0}}}) : angle_i;
  end

  always_ff @(posedge clk_i) begin
    if (en_i) begin
      x_q[0]    <= KInit;
      y_q[0]    <= '0;
      z_q[0]    <= signed'({ang_fold, {(ZW-ANGLE_W){1'b0}}});
      flip_q[0] <= flip_d;
    end
  end

  for (genvar i = 0; i < NStg; i++) begin : g_stage
    always_ff @(posedge clk_i) begin
      if (en_i) begin
        flip_q[i+1] <= flip_q[i];
        if (!z_q[i][ZW-1]) begin
          x_q[i+1] <= x_q[i] - (y_q[i] >>> i);
          y_q[i+1] <= y_q[i] + (x_q[i] >>> i);
        end else begin
          x_q[i+1] <= x_q[i] + (y_q[i] >>> i);
          y_q[i+1] <= y_q[i] - (x_q[i] >>> i);
        end
      end
    end
    if (i < NStg - 1) begin : g_z
      always_ff @(posedge clk_i) begin
        if (en_i) begin
          if (!z_q[i][ZW-1]) begin
            z_q[i+1] <= z_q[i] - ATAN_TAB[i];
          end else begin
            z_q[i+1] <= z_q[i] + ATAN_TAB[i];
          end
        end
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (en_i) begin
      cos_q <= flip_q[NStg] ? -x_q[NStg] : x_q[NStg];
      sin_q <= flip_q[NStg] ? -y_q[NStg] : y_q[NStg];
    end
  end

  assign cos_o = cos_q;
  assign sin_o = sin_q;

endmodule

// File: src/pose_point_transform_2d.sv
// Moves one lidar scan point into the frame of a previous pose. The point is
// first offset by the lidar mount translation and rotated by the mount angle,
// then offset by (current pose - reference pose) and rotated by the wrapped
// heading difference; each rotation is p' = R(a) * (p + t) with rounding to
// FRAC_BITS. Coordinates are signed Q16.16, angles are 16-bit binary angles
// (32768 = pi). Both final coordinates are clipped to 32 bits and saturated_o
// flags a clip. One word is taken per clock and one result word leaves per
// clock while the output is not stalled. Each accepted input word passes
// through the two cordic pipes running side by side, then through two
// multiply/round stage pairs. A stall on the output freezes the whole
// pipeline and shows up on in_stall_o. Registers are written through
// cfg_we_i/cfg_idx_i/cfg_data_i while no word is in flight; the user must
// ensure this, the block does not enforce it; indexes 6 and 7 are ignored.
module pose_point_transform_2d #(
  parameter int unsigned CORDIC_STAGES = pptf_pkg::CORDIC_STAGES_DEF,
  parameter int unsigned FRAC_BITS     = pptf_pkg::FRAC_BITS_DEF
) (
  input  logic                                   clk_i,
  input  logic                                   rst_ni,
  // configuration
  input  logic                                   cfg_we_i,
  input  logic [pptf_pkg::CFG_IDX_W-1:0]         cfg_idx_i,
  input  logic [pptf_pkg::CFG_DATA_W-1:0]        cfg_data_i,
  // input words
  input  logic                                   in_valid_i,
  output logic                                   in_stall_o,
  input  logic signed [pptf_pkg::COORD_W-1:0]    point_x_i,
  input  logic signed [pptf_pkg::COORD_W-1:0]    point_y_i,
  input  logic signed [pptf_pkg::COORD_W-1:0]    pose_x_i,
  input  logic signed [pptf_pkg::COORD_W-1:0]    pose_y_i,
  input  logic signed [pptf_pkg::ANGLE_W-1:0]    pose_angle_i,
  // result words
  output logic                                   out_valid_o,
  input  logic                                   out_stall_i,
  output logic signed [pptf_pkg::COORD_W-1:0]    result_x_o,
  output logic signed [pptf_pkg::COORD_W-1:0]    result_y_o,
  output logic                                   saturated_o
);
  import pptf_pkg::*;

  localparam int unsigned NStg = (CORDIC_STAGES < ATAN_LEN) ? CORDIC_STAGES : ATAN_LEN;
  localparam int unsigned Lat  = NStg + 2;          // cordic latency
  localparam int unsigned CW   = FRAC_BITS + 2;     // sin/cos width

  // first rotation: 33-bit point times sin/cos
  localparam int unsigned PW1 = SUM_W + CW;
  localparam int unsigned SW1 = PW1 + 1;
  // rotation gain is about sqrt(2) at most, so 34 bits hold the rotated point
  localparam int unsigned RW  = SUM_W + 1;
  localparam int unsigned X2W = RW + 1;
  // second rotation
  localparam int unsigned PW2 = X2W + CW;
  localparam int unsigned SW2 = PW2 + 1;

  localparam logic signed [SW1-1:0] Half1  = SW1'(longint'(1) << (FRAC_BITS - 1));
  localparam logic signed [SW2-1:0] Half2  = SW2'(longint'(1) << (FRAC_BITS - 1));
  localparam logic signed [SW2-1:0] SatMax = SW2'(RES_MAX);
  localparam logic signed [SW2-1:0] SatMin = SW2'(RES_MIN);

  // ---------------------------------------------------------------- config
  logic signed [COORD_W-1:0] mount_x_q, mount_y_q, ref_x_q, ref_y_q;
  logic signed [ANGLE_W-1:0] mount_ang_q, ref_ang_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      mount_x_q   <= MOUNT_X_RST;
      mount_y_q   <= MOUNT_Y_RST;
      mount_ang_q <= MOUNT_ANG_RST;
      ref_x_q     <= REF_X_RST;
      ref_y_q     <= REF_Y_RST;
      ref_ang_q   <= REF_ANG_RST;
    end else if (cfg_we_i) begin
      case (cfg_idx_i)
        REG_MOUNT_X:   mount_x_q   <= signed'(cfg_data_i[COORD_W-1:0]);
        REG_MOUNT_Y:   mount_y_q   <= signed'(cfg_data_i[COORD_W-1:0]);
        REG_MOUNT_ANG: mount_ang_q <= signed'(cfg_data_i[ANGLE_W-1:0]);
        REG_REF_X:     ref_x_q     <= signed'(cfg_data_i[COORD_W-1:0]);
        REG_REF_Y:     ref_y_q     <= signed'(cfg_data_i[COORD_W-1:0]);
        REG_REF_ANG:   ref_ang_q   <= signed'(cfg_data_i[ANGLE_W-1:0]);
        default: ;
      endcase
    end
  end

  // ---------------------------------------------------------- flow control
  // the whole pipe moves together; it only holds while a result waits
  logic pipe_en;
  assign pipe_en    = !(out_valid_o && out_stall_i);
  assign in_stall_o = !pipe_en;

  // ------------------------------------------------------------ entry stage
  pt_data_t           data_d;
  logic [ANGLE_W-1:0] dang;

  always_comb begin
    data_d.x  = SUM_W'(point_x_i) + SUM_W'(mount_x_q);
    data_d.y  = SUM_W'(point_y_i) + SUM_W'(mount_y_q);
    data_d.dx = SUM_W'(pose_x_i) - SUM_W'(ref_x_q);
    data_d.dy = SUM_W'(pose_y_i) - SUM_W'(ref_y_q);
    // heading difference wraps modulo a full turn
    dang      = pose_angle_i - ref_ang_q;
  end

  // ------------------------------------------------------------ sin/cos
  logic signed [CW-1:0] cos1, sin1, cos2, sin2;

  pptf_cordic #(
    .CORDIC_STAGES (CORDIC_STAGES),
    .FRAC_BITS     (FRAC_BITS)
  ) u_cordic_mount (
    .clk_i   (clk_i),
    .en_i    (pipe_en),
    .angle_i (mount_ang_q),
    .cos_o   (cos1),
    .sin_o   (sin1)
  );

  pptf_cordic #(
    .CORDIC_STAGES (CORDIC_STAGES),
    .FRAC_BITS     (FRAC_BITS)
  ) u_cordic_delta (
    .clk_i   (clk_i),
    .en_i    (pipe_en),
    .angle_i (dang),
    .cos_o   (cos2),
    .sin_o   (sin2)
  );

  // point data waits for the cordic results
  pt_data_t dly_q [Lat];
  logic     dly_v_q [Lat];

  always_ff @(posedge clk_i) begin
    if (pipe_en) begin
      dly_q[0] <= data_d;
      for (int k = 1; k < Lat; k++) begin
        dly_q[k] <= dly_q[k-1];
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      for (int k = 0; k < Lat; k++) begin
        dly_v_q[k] <= 1'b0;
      end
    end else if (pipe_en) begin
      dly_v_q[0] <= in_valid_i;
      for (int k = 1; k < Lat; k++) begin
        dly_v_q[k] <= dly_v_q[k-1];
      end
    end
  end

  // ------------------------------------------------ m1: mount rotation products
  logic signed [PW1-1:0]   m1_xc_q, m1_ys_q, m1_xs_q, m1_yc_q;
  logic signed [SUM_W-1:0] m1_dx_q, m1_dy_q;
  logic signed [CW-1:0]    m1_c2_q, m1_s2_q;
  logic                    m1_v_q;

  always_ff @(posedge clk_i) begin
    if (pipe_en) begin
      m1_xc_q <= PW1'(dly_q[Lat-1].x) * PW1'(cos1);
      m1_ys_q <= PW1'(dly_q[Lat-1].y) * PW1'(sin1);
      m1_xs_q <= PW1'(dly_q[Lat-1].x) * PW1'(sin1);
      m1_yc_q <= PW1'(dly_q[Lat-1].y) * PW1'(cos1);
      m1_dx_q <= dly_q[Lat-1].dx;
      m1_dy_q <= dly_q[Lat-1].dy;
      m1_c2_q <= cos2;
      m1_s2_q <= sin2;
    end
  end

  // ------------------------------------------- m2: round and add pose difference
  logic signed [X2W-1:0] m2_x_q, m2_y_q;
  logic signed [CW-1:0]  m2_c2_q, m2_s2_q;
  logic                  m2_v_q;
  logic signed [SW1-1:0] rot1_x, rot1_y;

  always_comb begin
    rot1_x = (SW1'(m1_xc_q) - SW1'(m1_ys_q) + Half1) >>> FRAC_BITS;
    rot1_y = (SW1'(m1_xs_q) + SW1'(m1_yc_q) + Half1) >>> FRAC_BITS;
  end

  always_ff @(posedge clk_i) begin
    if (pipe_en) begin
      m2_x_q  <= X2W'(signed'(rot1_x[RW-1:0])) + X2W'(m1_dx_q);
      m2_y_q  <= X2W'(signed'(rot1_y[RW-1:0])) + X2W'(m1_dy_q);
      m2_c2_q <= m1_c2_q;
      m2_s2_q <= m1_s2_q;
    end
  end

  // ---------------------------------------------- m3: delta rotation products
  logic signed [PW2-1:0] m3_xc_q, m3_ys_q, m3_xs_q, m3_yc_q;
  logic                  m3_v_q;

  always_ff @(posedge clk_i) begin
    if (pipe_en) begin
      m3_xc_q <= PW2'(m2_x_q) * PW2'(m2_c2_q);
      m3_ys_q <= PW2'(m2_y_q) * PW2'(m2_s2_q);
      m3_xs_q <= PW2'(m2_x_q) * PW2'(m2_s2_q);
      m3_yc_q <= PW2'(m2_y_q) * PW2'(m2_c2_q);
    end
  end

  // ------------------------------------------------ output: round and clip
  logic signed [SW2-1:0]     rot2_x, rot2_y;
  logic                      hi_x, lo_x, hi_y, lo_y;
  logic signed [COORD_W-1:0] res_x_d, res_y_d;
  logic signed [COORD_W-1:0] res_x_q, res_y_q;
  logic                      sat_q, out_v_q;

  always_comb begin
    rot2_x  = (SW2'(m3_xc_q) - SW2'(m3_ys_q) + Half2) >>> FRAC_BITS;
    rot2_y  = (SW2'(m3_xs_q) + SW2'(m3_yc_q) + Half2) >>> FRAC_BITS;
    hi_x    = rot2_x > SatMax;
    lo_x    = rot2_x < SatMin;
    hi_y    = rot2_y > SatMax;
    lo_y    = rot2_y < SatMin;
    res_x_d = hi_x ? RES_MAX : (lo_x ? RES_MIN : signed'(rot2_x[COORD_W-1:0]));
    res_y_d = hi_y ? RES_MAX : (lo_y ? RES_MIN : signed'(rot2_y[COORD_W-1:0]));
  end

  always_ff @(posedge clk_i) begin
    if (pipe_en) begin
      res_x_q <= res_x_d;
      res_y_q <= res_y_d;
      sat_q   <= hi_x | lo_x | hi_y | lo_y;
    end
  end

  // valid bits of the arithmetic stages
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      m1_v_q  <= 1'b0;
      m2_v_q  <= 1'b0;
      m3_v_q  <= 1'b0;
      out_v_q <= 1'b0;
    end else if (pipe_en) begin
      m1_v_q  <= dly_v_q[Lat-1];
      m2_v_q  <= m1_v_q;
      m3_v_q  <= m2_v_q;
      out_v_q <= m3_v_q;
    end
  end

  assign out_valid_o = out_v_q;
  assign result_x_o  = res_x_q;
  assign result_y_o  = res_y_q;
  assign saturated_o = sat_q;

  // ------------------------------------------------------------ checks
  // an accepted word enters the delay line
  a_accept_enters: assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_valid_i && !in_stall_o |=> dly_v_q[0])
    else $error("accepted word not captured");

  // a held pipeline keeps its inner valid bits
  a_freeze_holds: assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_stall_o |=> $stable(m1_v_q) && $stable(m3_v_q) && $stable(dly_v_q[Lat-1]))
    else $error("pipeline moved while stalled");

  // a flagged clip shows a limit value on one of the coordinates
  a_sat_limit: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && saturated_o |->
      (result_x_o == RES_MAX || result_x_o == RES_MIN ||
       result_y_o == RES_MAX || result_y_o == RES_MIN))
    else $error("saturated set without a clipped coordinate");

endmodule

// File: sim/testbench.sv
module testbench;
  import pptf_pkg::*;

  localparam int STAGES = CORDIC_STAGES_DEF;
  localparam int FRAC   = FRAC_BITS_DEF;
  // pipeline depth of the block, plus slack
  localparam int DRAIN_CYCLES = 40;
  localparam int QUIET_LIMIT  = 2000;
  localparam int HOLD_CYCLES  = 300;
  localparam int PHASES       = 8;
  localparam int PHASE_WORDS  = 95;

  // indexes the block has no register behind
  localparam logic [CFG_IDX_W-1:0] REG_SPARE_A = 3'd6;
  localparam logic [CFG_IDX_W-1:0] REG_SPARE_B = 3'd7;

  typedef struct packed {
    logic signed [COORD_W-1:0] point_x;
    logic signed [COORD_W-1:0] point_y;
    logic signed [COORD_W-1:0] pose_x;
    logic signed [COORD_W-1:0] pose_y;
    logic signed [ANGLE_W-1:0] pose_angle;
  } scan_word_t;

  typedef struct packed {
    logic signed [COORD_W-1:0] x;
    logic signed [COORD_W-1:0] y;
    logic                      clipped;
  } frame_point_t;

  // holds the register copy and the points still owed by the block
  class frame_point_board;
    logic signed [COORD_W-1:0] mount_x   = MOUNT_X_RST;
    logic signed [COORD_W-1:0] mount_y   = MOUNT_Y_RST;
    logic        [ANGLE_W-1:0] mount_ang = MOUNT_ANG_RST;
    logic signed [COORD_W-1:0] ref_x     = REF_X_RST;
    logic signed [COORD_W-1:0] ref_y     = REF_Y_RST;
    logic        [ANGLE_W-1:0] ref_ang   = REF_ANG_RST;
    frame_point_t owed_points[$];
    int errors = 0;

    function int pending();
      return owed_points.size();
    endfunction

    function void set_reg(logic [CFG_IDX_W-1:0] idx, logic [CFG_DATA_W-1:0] data);
      case (idx)
        REG_MOUNT_X:   mount_x = data;
        REG_MOUNT_Y:   mount_y = data;
        REG_MOUNT_ANG: mount_ang = data[ANGLE_W-1:0];
        REG_REF_X:     ref_x = data;
        REG_REF_Y:     ref_y = data;
        REG_REF_ANG:   ref_ang = data[ANGLE_W-1:0];
        default: ;
      endcase
    endfunction

    // cordic rotation mode, quadrants 2 and 3 folded by a half turn
    function void sin_cos(logic [ANGLE_W-1:0] ang, output longint c, output longint s);
      logic [31:0] th;
      bit flip;
      longint x, y, z, dx, dy;
      th = {ang, 16'h0000};
      flip = (th[31:30] == 2'b01) || (th[31:30] == 2'b10);
      if (flip) th = th - 32'h8000_0000;
      z = longint'($signed(th));
      x = longint'((64'd652032874 + (64'd1 << (29 - FRAC))) >> (30 - FRAC));
      y = 0;
      for (int i = 0; i < STAGES && i < ATAN_LEN; i++) begin
        dx = y >>> i;
        dy = x >>> i;
        if (z >= 0) begin
          x = x - dx;
          y = y + dy;
          z = z - longint'(ATAN_TAB[i]);
        end else begin
          x = x + dx;
          y = y - dy;
          z = z + longint'(ATAN_TAB[i]);
        end
      end
      c = flip ? -x : x;
      s = flip ? -y : y;
    endfunction

    function void rotate_pt(logic [ANGLE_W-1:0] ang, inout longint x, inout longint y);
      longint c, s, x0, y0, half;
      half = longint'(1) << (FRAC - 1);
      sin_cos(ang, c, s);
      x0 = x;
      y0 = y;
      x = (c * x0 - s * y0 + half) >>> FRAC;
      y = (s * x0 + c * y0 + half) >>> FRAC;
    endfunction

    function logic signed [COORD_W-1:0] clip32(longint v, inout bit hit);
      if (v > 64'sd2147483647) begin
        hit = 1'b1;
        return RES_MAX;
      end
      if (v < -64'sd2147483648) begin
        hit = 1'b1;
        return RES_MIN;
      end
      return v[COORD_W-1:0];
    endfunction

    // mount transform first, then the pose difference with wrapped heading
    function void note_point(scan_word_t w);
      longint x, y;
      logic [ANGLE_W-1:0] dang;
      bit hit;
      frame_point_t p;
      hit = 1'b0;
      x = longint'(w.point_x) + longint'(mount_x);
      y = longint'(w.point_y) + longint'(mount_y);
      dang = w.pose_angle - ref_ang;
      rotate_pt(mount_ang, x, y);
      x = x + longint'(w.pose_x) - longint'(ref_x);
      y = y + longint'(w.pose_y) - longint'(ref_y);
      rotate_pt(dang, x, y);
      p.x = clip32(x, hit);
      p.y = clip32(y, hit);
      p.clipped = hit;
      owed_points.push_back(p);
    endfunction

    function void mismatch(string what, longint exp_v, longint act_v);
      errors++;
      $display("%0t: %s expected %0d got %0d", $time, what, exp_v, act_v);
    endfunction

    function void check_result(logic signed [COORD_W-1:0] rx, logic signed [COORD_W-1:0] ry,
                               logic sat);
      frame_point_t p;
      if (owed_points.size() == 0) begin
        errors++;
        $display("%0t: result word with none expected, x %0d y %0d", $time, rx, ry);
        return;
      end
      p = owed_points.pop_front();
      if (rx !== p.x) mismatch("result_x", p.x, rx);
      if (ry !== p.y) mismatch("result_y", p.y, ry);
      if (sat !== p.clipped) mismatch("saturated", p.clipped, sat);
    endfunction
  endclass

  frame_point_board board = new();

  logic clk = 1'b0;
  logic rst_ni = 1'b0;
  logic cfg_we = 1'b0;
  logic [CFG_IDX_W-1:0] cfg_idx = '0;
  logic [CFG_DATA_W-1:0] cfg_data = '0;
  logic in_valid = 1'b0;
  logic in_stall_o;
  logic signed [COORD_W-1:0] pt_x = '0, pt_y = '0, ps_x = '0, ps_y = '0;
  logic signed [ANGLE_W-1:0] ps_ang = '0;
  logic out_valid_o;
  logic out_stall = 1'b0;
  logic signed [COORD_W-1:0] result_x_o, result_y_o;
  logic saturated_o;

  // receiver asks for one long hold-off when this is set
  bit hold_req = 1'b0;
  int quiet_cycles = 0;

  pose_point_transform_2d dut (
    .clk_i        (clk),
    .rst_ni       (rst_ni),
    .cfg_we_i     (cfg_we),
    .cfg_idx_i    (cfg_idx),
    .cfg_data_i   (cfg_data),
    .in_valid_i   (in_valid),
    .in_stall_o   (in_stall_o),
    .point_x_i    (pt_x),
    .point_y_i    (pt_y),
    .pose_x_i     (ps_x),
    .pose_y_i     (ps_y),
    .pose_angle_i (ps_ang),
    .out_valid_o  (out_valid_o),
    .out_stall_i  (out_stall),
    .result_x_o   (result_x_o),
    .result_y_o   (result_y_o),
    .saturated_o  (saturated_o)
  );

  always begin
    #4 clk = 1'b1;
    #4 clk = 1'b0;
  end

  // both handshakes are sampled here with their values from before the edge
  always @(posedge clk) begin
    scan_word_t w;
    bit moved;
    moved = 1'b0;
    if (rst_ni) begin
      if (in_valid && !in_stall_o) begin
        w.point_x = pt_x;
        w.point_y = pt_y;
        w.pose_x = ps_x;
        w.pose_y = ps_y;
        w.pose_angle = ps_ang;
        board.note_point(w);
        moved = 1'b1;
      end
      if (out_valid_o && !out_stall) begin
        board.check_result(result_x_o, result_y_o, saturated_o);
        moved = 1'b1;
      end
      // watchdog on cycles in which no word moves on either side
      quiet_cycles = moved ? 0 : quiet_cycles + 1;
      if (quiet_cycles >= QUIET_LIMIT) begin
        $display("%0t: no word moved for %0d cycles", $time, QUIET_LIMIT);
        $display("DONE: errors detected");
        $finish;
      end
    end
  end

  // receiver: free stretches, short and long stalls, one long hold-off on request
  initial begin
    int run;
    int r;
    wait (rst_ni === 1'b1);
    @(posedge clk);
    forever begin
      if (hold_req) begin
        hold_req = 1'b0;
        out_stall <= 1'b1;
        repeat (HOLD_CYCLES) @(posedge clk);
      end
      r = $urandom_range(0, 99);
      if (r < 25) begin
        out_stall <= 1'b0;
        run = $urandom_range(20, 120);
      end else if (r < 70) begin
        out_stall <= 1'b0;
        run = $urandom_range(1, 4);
      end else if (r < 95) begin
        out_stall <= 1'b1;
        run = $urandom_range(1, 3);
      end else begin
        out_stall <= 1'b1;
        run = $urandom_range(10, 40);
      end
      repeat (run) @(posedge clk);
    end
  end

  function automatic scan_word_t mk(logic [31:0] px, logic [31:0] py, logic [31:0] qx,
                                    logic [31:0] qy, logic [15:0] qa);
    scan_word_t w;
    w.point_x = px;
    w.point_y = py;
    w.pose_x = qx;
    w.pose_y = qy;
    w.pose_angle = qa;
    return w;
  endfunction

  // realistic metres, full-range noise, or a corner of the field
  function automatic logic [31:0] pick_coord(int style);
    logic [31:0] r;
    case (style)
      0: begin
        r = $urandom_range(0, 32'h00FF_FFFF);
        return r - 32'h0080_0000;
      end
      1: return $urandom();
      default: begin
        case ($urandom_range(0, 5))
          0: return 32'h7FFF_FFFF;
          1: return 32'h8000_0000;
          2: return 32'h0000_0000;
          3: return 32'hFFFF_FFFF;
          4: return 32'h0001_0000;
          default: return $urandom();
        endcase
      end
    endcase
  endfunction

  function automatic scan_word_t random_word();
    int r;
    int style;
    logic [15:0] qa;
    r = $urandom_range(0, 99);
    style = (r < 60) ? 0 : (r < 85) ? 1 : 2;
    // heading near a quadrant edge of the difference, or anywhere
    if ($urandom_range(0, 99) < 40)
      qa = board.ref_ang + 16'(16384 * $urandom_range(0, 3)) + 16'($urandom_range(0, 4))
           - 16'd2;
    else
      qa = 16'($urandom_range(0, 16'hFFFF));
    return mk(pick_coord(style), pick_coord(style), pick_coord(style), pick_coord(style), qa);
  endfunction

  // mostly back to back, sometimes a few cycles, rarely a long pause
  function automatic int pick_gap();
    int r;
    r = $urandom_range(0, 99);
    if (r < 50) return 0;
    if (r < 85) return $urandom_range(1, 3);
    if (r < 97) return $urandom_range(4, 10);
    return $urandom_range(20, 60);
  endfunction

  // called at a rising edge; returns at the edge where the word is taken
  task automatic send_word(input scan_word_t w, input bit no_gaps);
    int gap;
    gap = no_gaps ? 0 : pick_gap();
    if (gap > 0) begin
      in_valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    in_valid <= 1'b1;
    pt_x <= w.point_x;
    pt_y <= w.point_y;
    ps_x <= w.pose_x;
    ps_y <= w.pose_y;
    ps_ang <= w.pose_angle;
    @(posedge clk);
    while (in_stall_o) @(posedge clk);
  endtask

  // stop offering words and let every owed result come out
  task automatic settle();
    in_valid <= 1'b0;
    while (board.pending() != 0) @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);
  endtask

  task automatic write_reg(input logic [CFG_IDX_W-1:0] idx, input logic [CFG_DATA_W-1:0] data);
    cfg_we <= 1'b1;
    cfg_idx <= idx;
    cfg_data <= data;
    @(posedge clk);
    board.set_reg(idx, data);
    cfg_we <= 1'b0;
    @(posedge clk);
  endtask

  initial begin
    scan_word_t directed[$];
    logic [31:0] junk;
    repeat (3) @(posedge clk);
    rst_ni <= 1'b1;
    @(posedge clk);

    // reset settings: quadrant edges of the heading difference, wrap, clipping
    directed.push_back(mk(0, 0, 0, 0, 0));
    directed.push_back(mk(32'h0001_0000, 0, 0, 0, 16'd8192));
    directed.push_back(mk(32'h0001_0000, 32'h0002_0000, 0, 0, 16'd8192 + 16'd16384));
    directed.push_back(mk(32'h0001_0000, 32'h0002_0000, 0, 0, 16'd8192 - 16'd16384));
    directed.push_back(mk(32'h0003_0000, 32'hFFFF_0000, 0, 0, 16'd8192 + 16'd32768));
    directed.push_back(mk(32'h0003_0000, 32'hFFFF_0000, 0, 0, 16'd8192 + 16'd32767));
    directed.push_back(mk(32'h0005_8000, 32'h0001_0000, 32'h0010_0000, 0, 16'h8000));
    directed.push_back(mk(32'h0005_8000, 32'h0001_0000, 0, 32'h0010_0000, 16'h7FFF));
    directed.push_back(mk(32'h7FFF_FFFF, 32'h7FFF_FFFF, 32'h7FFF_FFFF, 32'h7FFF_FFFF, 16'd8192));
    directed.push_back(mk(32'h8000_0000, 32'h8000_0000, 32'h8000_0000, 32'h8000_0000, 16'd8192));
    directed.push_back(mk(32'h7FFF_FFFF, 32'h8000_0000, 0, 0, 16'd0));
    directed.push_back(mk(0, 0, 32'h7FFF_FFFF, 0, 16'd8192));
    directed.push_back(mk(0, 0, 32'h8000_0000, 0, 16'd8192));
    directed.push_back(mk(32'h8000_0000, 0, 32'h8000_0000, 0, 16'd8192));
    directed.push_back(mk(32'hFFFF_FFFF, 32'hFFFF_FFFF, 32'hFFFF_FFFF, 32'hFFFF_FFFF, 16'hFFFF));
    directed.push_back(mk(32'h5555_5555, 32'hAAAA_AAAA, 32'h5555_5555, 32'hAAAA_AAAA, 16'h5555));
    directed.push_back(mk(32'hAAAA_AAAA, 32'h5555_5555, 32'hAAAA_AAAA, 32'h5555_5555, 16'hAAAA));
    directed.push_back(mk(0, 32'h7FFF_FFFF, 0, 32'h7FFF_FFFF, 16'd8192 + 16'd16384));
    foreach (directed[i]) send_word(directed[i], 1'b0);
    repeat (40) send_word(random_word(), 1'b0);

    for (int ph = 1; ph <= PHASES; ph++) begin
      // the sender waits here until every owed result has come
      settle();
      junk = $urandom();
      case (ph)
        1: begin
          write_reg(REG_MOUNT_X, 32'h7FFF_FFFF);
          write_reg(REG_MOUNT_Y, 32'h7FFF_FFFF);
          write_reg(REG_MOUNT_ANG, {junk[31:16], 16'h7FFF});
          write_reg(REG_REF_X, 32'h7FFF_FFFF);
          write_reg(REG_REF_Y, 32'h7FFF_FFFF);
          write_reg(REG_REF_ANG, {junk[15:0], 16'h7FFF});
          write_reg(REG_SPARE_A, $urandom());
        end
        2: begin
          write_reg(REG_MOUNT_X, 32'h8000_0000);
          write_reg(REG_MOUNT_Y, 32'h8000_0000);
          write_reg(REG_MOUNT_ANG, {junk[31:16], 16'h8000});
          write_reg(REG_REF_X, 32'h8000_0000);
          write_reg(REG_REF_Y, 32'h8000_0000);
          write_reg(REG_REF_ANG, {junk[15:0], 16'h8000});
        end
        3: begin
          write_reg(REG_MOUNT_X, 32'h0);
          write_reg(REG_MOUNT_Y, 32'h0);
          write_reg(REG_MOUNT_ANG, 32'h0);
          write_reg(REG_REF_X, 32'h0);
          write_reg(REG_REF_Y, 32'h0);
          write_reg(REG_REF_ANG, 32'h0);
          // writes to the spare indexes must leave all of the above alone
          write_reg(REG_SPARE_A, 32'hFFFF_FFFF);
          write_reg(REG_SPARE_B, 32'hFFFF_FFFF);
        end
        default: begin
          write_reg(REG_MOUNT_X, pick_coord(0));
          write_reg(REG_MOUNT_Y, pick_coord(0));
          write_reg(REG_MOUNT_ANG, $urandom());
          write_reg(REG_REF_X, pick_coord($urandom_range(0, 1)));
          write_reg(REG_REF_Y, pick_coord($urandom_range(0, 1)));
          write_reg(REG_REF_ANG, $urandom());
          if (ph == 7) write_reg(REG_SPARE_B, $urandom());
        end
      endcase

      // phase 4: receiver holds off while words keep coming, so the block backs up
      if (ph == 4) begin
        hold_req = 1'b1;
        // start sending only once the receiver has begun its hold-off
        wait (!hold_req);
      end
      repeat (PHASE_WORDS) send_word(random_word(), (ph == 4) || (ph == 6));
    end

    settle();
    if (board.errors == 0 && board.pending() == 0) begin
      $display("DONE: 0 errors");
    end else begin
      $display("DONE: errors detected");
    end
    $finish;
  end

endmodule

// File: filelist.f
src/pptf_pkg.sv
src/pptf_cordic.sv
src/pose_point_transform_2d.sv
sim/testbench.sv
